/* rtl/sprite_line_rle_decoder_core_defines.svh */
// ----------------------------------------------------------------------------
// Sprite line RLE decoder assertion macros
// Shared assertion forms for the decoder core, clocked on clk and held off
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPRITE_LINE_RLE_DECODER_CORE_DEFINES_SVH
`define SPRITE_LINE_RLE_DECODER_CORE_DEFINES_SVH

// A property that must hold at every clock edge.
`define SRLE_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define SRLE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/srle_pkg.sv */
// ----------------------------------------------------------------------------
// Sprite line RLE decoder package
// Types, register indexes and helper functions shared by the decoder modules.
// ----------------------------------------------------------------------------
package srle_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 2'd2;

	localparam logic [15:0] FRAME_WIDTH_RESET = 16'd256;

	localparam logic [7:0] SKIP_MIN = 8'h80;
	localparam logic [7:0] RUN_MIN = 8'h41;
	localparam logic [7:0] RUN_MAX = 8'h7F;
	localparam logic [7:0] LIT_NONE = 8'h00;

	typedef enum logic [1:0] {
		ST_CMD,
		ST_RUNCOL,
		ST_LIT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_LIT,
		CLS_RUN,
		CLS_SKIP
	} cls_t;

	typedef struct packed {
		logic line_init;
		logic skip;
		logic load_run;
		logic load_lit;
		logic dec_lit;
		logic latch_color;
		logic emit;
		logic emit_color;
		logic emit_last;
		logic dec_run;
	} ctrl_cmd_t;

	typedef struct packed {
		cls_t cls;
		logic lit_one;
		logic run_one;
		logic out_free;
	} dp_sts_t;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

endpackage

/* rtl/srle_if.sv */
// ----------------------------------------------------------------------------
// Sprite line RLE decoder channel interfaces
// Valid/ready channels for encoded bytes, pixel writes and register writes.
// ----------------------------------------------------------------------------
interface srle_in_if;
	logic valid;
	logic ready;
	logic [7:0] code_byte;
	logic line_start;

	modport source (output valid, output code_byte, output line_start, input ready);
	modport sink (input valid, input code_byte, input line_start, output ready);
endinterface

interface srle_out_if;
	logic valid;
	logic ready;
	logic [15:0] pixel_column;
	logic [15:0] pixel_row;
	logic [7:0] pixel_value;
	logic out_of_range;
	logic last_of_run;

	modport source (output valid, output pixel_column, output pixel_row,
		output pixel_value, output out_of_range, output last_of_run, input ready);
	modport sink (input valid, input pixel_column, input pixel_row,
		input pixel_value, input out_of_range, input last_of_run, output ready);
endinterface

interface srle_cfg_if;
	logic valid;
	logic ready;
	logic [srle_pkg::CFG_IDX_W-1:0] index;
	logic [srle_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/sprite_line_rle_decoder_core.sv */
// ----------------------------------------------------------------------------
// Sprite line RLE decoder core
// Decodes run-length encoded sprite lines into pixel write transactions.
//
// Channel   Direction  Transaction
// code_in   sink       one encoded byte with its line start flag
// pixel_out source     one pixel write: column, row, value and flags
// cfg       sink       one register write: index and data
//
// Each command or literal byte is taken on its own; a literal byte also loads
// its pixel into the output register. A run color byte latches its color, and
// then its run emits one pixel per cycle while the output register is free, with code_in held off.
// A byte is taken only when the output register is empty or being drained in
// the same cycle, so a stalled pixel_out stalls code_in.
// Reset leaves no pixel pending and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "sprite_line_rle_decoder_core_defines.svh"

module sprite_line_rle_decoder_core (
	input logic clk,
	input logic arst_n,
	srle_in_if.sink code_in,
	srle_out_if.source pixel_out,
	srle_cfg_if.sink cfg
);

	srle_pkg::ctrl_cmd_t cmd;
	srle_pkg::dp_sts_t sts;
	srle_pkg::state_t ctrl_st;
	logic in_accept;
	logic out_accept;
	logic run_busy;
	logic lit_take;
	logic line_take;

	assign cfg.ready = 1'b1;
	assign in_accept = code_in.valid && code_in.ready;
	assign out_accept = pixel_out.valid && pixel_out.ready;
	assign run_busy = (ctrl_st == srle_pkg::ST_EMIT);
	assign lit_take = in_accept && !code_in.line_start && ctrl_st == srle_pkg::ST_LIT;
	assign line_take = in_accept && code_in.line_start;

	srle_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(code_in.valid),
		.line_start(code_in.line_start),
		.in_ready(code_in.ready),
		.sts(sts),
		.cmd(cmd),
		.state(ctrl_st)
	);

	srle_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.code_byte(code_in.code_byte),
		.cfg_we(cfg.valid && cfg.ready),
		.cfg_index(cfg.index),
		.cfg_data(cfg.data),
		.cmd(cmd),
		.sts(sts),
		.out_valid(pixel_out.valid),
		.out_ready(pixel_out.ready),
		.pixel_column(pixel_out.pixel_column),
		.pixel_row(pixel_out.pixel_row),
		.pixel_value(pixel_out.pixel_value),
		.out_of_range(pixel_out.out_of_range),
		.last_of_run(pixel_out.last_of_run)
	);

	`SRLE_ASSERT_ALWAYS(a_no_input_in_run, !(run_busy && code_in.ready), "code_in open in a run")
	`SRLE_ASSERT_NEXT(a_literal_emits, lit_take, pixel_out.valid && pixel_out.last_of_run, "no literal")
	`SRLE_ASSERT_NEXT(a_run_continues, out_accept && !pixel_out.last_of_run, pixel_out.valid, "run gap")
	`SRLE_ASSERT_NEXT(a_line_start_is_command, line_take, !run_busy, "line start not a command")

endmodule

/* rtl/srle_dp.sv */
// ----------------------------------------------------------------------------
// Sprite line RLE decoder datapath
// Holds the registers, the column and row position, the run and literal
// counters and the pixel output register.
// ----------------------------------------------------------------------------
module srle_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] code_byte,
	input  logic cfg_we,
	input  logic [srle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  srle_pkg::ctrl_cmd_t cmd,
	output srle_pkg::dp_sts_t sts,
	output logic out_valid,
	input  logic out_ready,
	output logic [15:0] pixel_column,
	output logic [15:0] pixel_row,
	output logic [7:0] pixel_value,
	output logic out_of_range,
	output logic last_of_run
);

	logic [15:0] frame_width_q;
	logic [7:0] x_offset_q;
	logic [7:0] y_offset_q;
	logic [15:0] column_q;
	logic [15:0] row_q;
	logic seen_q;
	logic [6:0] lit_q;
	logic [5:0] run_q;
	logic [7:0] color_q;
	logic out_valid_q;
	logic [15:0] col_base;
	logic [7:0] emit_value;
	srle_pkg::cls_t cls;

	always_comb begin
		case (code_byte) inside
			[srle_pkg::SKIP_MIN:8'hFF]: cls = srle_pkg::CLS_SKIP;
			[srle_pkg::RUN_MIN:srle_pkg::RUN_MAX]: cls = srle_pkg::CLS_RUN;
			srle_pkg::LIT_NONE: cls = srle_pkg::CLS_ZERO;
			default: cls = srle_pkg::CLS_LIT;
		endcase
	end

	assign sts.cls = cls;
	assign sts.lit_one = (lit_q == 7'd1);
	assign sts.run_one = (run_q == 6'd1);
	assign sts.out_free = !out_valid_q || out_ready;

	assign col_base = cmd.line_init ? {8'd0, x_offset_q} : column_q;
	assign emit_value = cmd.emit_color ? color_q : code_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= srle_pkg::FRAME_WIDTH_RESET;
			x_offset_q <= '0;
			y_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				srle_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_data;
				srle_pkg::REG_X_OFFSET: x_offset_q <= cfg_data[7:0];
				srle_pkg::REG_Y_OFFSET: y_offset_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q <= '0;
			seen_q <= 1'b0;
			lit_q <= '0;
			run_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.skip) begin
				column_q <= srle_pkg::sat_add16(col_base, {9'd0, code_byte[6:0]});
			end else if (cmd.line_init) begin
				column_q <= col_base;
			end else if (cmd.emit) begin
				column_q <= srle_pkg::sat_add16(column_q, 16'd1);
			end
			if (cmd.line_init) begin
				row_q <= seen_q ? srle_pkg::sat_add16(row_q, 16'd1) : {8'd0, y_offset_q};
				seen_q <= 1'b1;
			end
			if (cmd.load_lit) begin
				lit_q <= code_byte[6:0];
			end else if (cmd.dec_lit) begin
				lit_q <= lit_q - 7'd1;
			end
			if (cmd.load_run) begin
				run_q <= code_byte[5:0];
			end else if (cmd.dec_run) begin
				run_q <= run_q - 6'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_color) begin
			color_q <= code_byte;
		end
		if (cmd.emit) begin
			pixel_column <= column_q;
			pixel_row <= row_q;
			pixel_value <= emit_value;
			out_of_range <= (column_q >= frame_width_q);
			last_of_run <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/srle_ctrl.sv */
// ----------------------------------------------------------------------------
// Sprite line RLE decoder controller
// Tracks what the next encoded byte means and sequences the pixel writes of
// each run.
// ----------------------------------------------------------------------------
module srle_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic line_start,
	output logic in_ready,
	input  srle_pkg::dp_sts_t sts,
	output srle_pkg::ctrl_cmd_t cmd,
	output srle_pkg::state_t state
);

	srle_pkg::state_t state_q;
	srle_pkg::state_t state_d;
	srle_pkg::state_t eff_state;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srle_pkg::ST_CMD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		in_ready = (state_q != srle_pkg::ST_EMIT) && sts.out_free;
		accept = in_valid && in_ready;
		eff_state = line_start ? srle_pkg::ST_CMD : state_q;
		cmd = '0;
		state_d = state_q;
		if (state_q == srle_pkg::ST_EMIT) begin
			if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.emit_color = 1'b1;
				cmd.emit_last = sts.run_one;
				cmd.dec_run = 1'b1;
				if (sts.run_one) begin
					state_d = srle_pkg::ST_CMD;
				end
			end
		end else if (accept) begin
			cmd.line_init = line_start;
			case (eff_state)
				srle_pkg::ST_RUNCOL: begin
					cmd.latch_color = 1'b1;
					state_d = srle_pkg::ST_EMIT;
				end
				srle_pkg::ST_LIT: begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.dec_lit = 1'b1;
					state_d = sts.lit_one ? srle_pkg::ST_CMD : srle_pkg::ST_LIT;
				end
				default: begin
					state_d = srle_pkg::ST_CMD;
					case (sts.cls)
						srle_pkg::CLS_SKIP: cmd.skip = 1'b1;
						srle_pkg::CLS_RUN: begin
							cmd.load_run = 1'b1;
							state_d = srle_pkg::ST_RUNCOL;
						end
						srle_pkg::CLS_LIT: begin
							cmd.load_lit = 1'b1;
							state_d = srle_pkg::ST_LIT;
						end
						default: ;
					endcase
				end
			endcase
		end
	end

	assign state = state_q;

endmodule

/* tb/sv/sprite_line_rle_decoder_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite line RLE decoder core testbench
// Feeds encoded sprite lines into the decoder and checks every pixel write
// against a cycle-free model of the decoder kept inside the bench. A short
// scripted sequence covers the reset values, the command classes and the
// line start rules. Random well-formed lines with some broken lines and
// noise follow under several register settings, including a zero frame
// width and a maximum frame width. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sprite_line_rle_decoder_core_tb;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [7:0] RUN_BASE = 8'h40;

	typedef enum logic [1:0] {
		DEC_CMD,
		DEC_RUN,
		DEC_LIT
	} dec_mode_t;

	typedef enum logic [1:0] {
		DRAIN_FREE,
		DRAIN_RANDOM,
		DRAIN_PERIODIC,
		DRAIN_SPARSE
	} drain_mode_t;

	typedef enum logic {
		ROW_BYTE,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		logic [15:0] column;
		logic [15:0] row;
		logic [7:0] value;
		logic oor;
		logic last;
	} pixel_t;

	typedef struct packed {
		row_kind_t kind;
		logic [srle_pkg::CFG_IDX_W-1:0] idx;
		logic [15:0] data;
		logic ls;
		logic typed;
		pixel_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	srle_in_if code_if ();
	srle_out_if pix_if ();
	srle_cfg_if cfg_if ();

	sprite_line_rle_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.code_in(code_if),
		.pixel_out(pix_if),
		.cfg(cfg_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [15:0] fw_q = srle_pkg::FRAME_WIDTH_RESET;
	logic [7:0] x_off_q = 8'd0;
	logic [7:0] y_off_q = 8'd0;
	dec_mode_t mode_q = DEC_CMD;
	logic [6:0] lit_left_q = 7'd0;
	logic [5:0] run_len_q = 6'd0;
	logic [15:0] col_q = 16'd0;
	logic [15:0] row_q = 16'd0;
	logic seen_line_q = 1'b0;

	pixel_t pix_expected[$];
	pixel_t want_pix;
	script_row_t script[$];
	int fail_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned burst_left = 0;
	bit steady = 1'b0;
	int unsigned quiet_cycles = 0;
	drain_mode_t drain_mode = DRAIN_FREE;
	int unsigned drain_span = 0;
	logic [3:0] drain_tick = 4'd0;

	function automatic logic [15:0] add_clamped(input logic [15:0] a, input logic [15:0] b);
		return (a > 16'hFFFF - b) ? 16'hFFFF : a + b;
	endfunction

	function automatic void put_pixel(input logic [7:0] value, input logic last);
		pixel_t p;
		p.column = col_q;
		p.row = row_q;
		p.value = value;
		p.oor = (col_q >= fw_q);
		p.last = last;
		pix_expected.insert(pix_expected.size(), p);
		col_q = add_clamped(col_q, 16'd1);
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic ls);
		int unsigned i;
		if (ls) begin
			col_q = {8'd0, x_off_q};
			row_q = seen_line_q ? add_clamped(row_q, 16'd1) : {8'd0, y_off_q};
			seen_line_q = 1'b1;
			mode_q = DEC_CMD;
			lit_left_q = 7'd0;
			run_len_q = 6'd0;
		end
		case (mode_q)
			DEC_RUN: begin
				for (i = 1; i <= run_len_q; i++)
					put_pixel(b, i == run_len_q);
				run_len_q = 6'd0;
				mode_q = DEC_CMD;
			end
			DEC_LIT: begin
				put_pixel(b, 1'b1);
				lit_left_q = 7'(lit_left_q - 7'd1);
				if (lit_left_q == 7'd0)
					mode_q = DEC_CMD;
			end
			default: begin
				if (b >= srle_pkg::SKIP_MIN) begin
					col_q = add_clamped(col_q, 16'(b - srle_pkg::SKIP_MIN));
				end else if (b >= srle_pkg::RUN_MIN) begin
					run_len_q = 6'(b - RUN_BASE);
					mode_q = DEC_RUN;
				end else if (b != srle_pkg::LIT_NONE) begin
					lit_left_q = 7'(b);
					mode_q = DEC_LIT;
				end
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
			if (pix_expected.size() == 0) begin
				$error("Pixel transaction with nothing outstanding: column %0d, row %0d",
					pix_if.pixel_column, pix_if.pixel_row);
				fail_count++;
			end else begin
				want_pix = pix_expected.pop_front();
				check_field("pixel_column", want_pix.column, pix_if.pixel_column);
				check_field("pixel_row", want_pix.row, pix_if.pixel_row);
				check_field("pixel_value", 16'(want_pix.value), 16'(pix_if.pixel_value));
				check_field("out_of_range", 16'(want_pix.oor), 16'(pix_if.out_of_range));
				check_field("last_of_run", 16'(want_pix.last), 16'(pix_if.last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if (drain_span == 0) begin
			drain_mode <= drain_mode_t'($urandom_range(0, 3));
			drain_span <= $urandom_range(50, 300);
		end else begin
			drain_span <= drain_span - 1;
		end
		drain_tick <= drain_tick + 4'd1;
		case (drain_mode)
			DRAIN_FREE: pix_if.ready <= 1'b1;
			DRAIN_RANDOM: pix_if.ready <= ($urandom_range(0, 3) != 0);
			DRAIN_PERIODIC: pix_if.ready <= (drain_tick < 4'd11);
			default: pix_if.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (code_if.valid && code_if.ready) || (pix_if.valid && pix_if.ready)
			|| (cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$error("No transaction for %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic ls);
		if (!steady && burst_left == 0) begin
			code_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		code_if.valid <= 1'b1;
		code_if.code_byte <= b;
		code_if.line_start <= ls;
		@(posedge clk);
		while (code_if.ready !== 1'b1) @(posedge clk);
		decode_byte(b, ls);
		bytes_sent++;
		if (burst_left != 0)
			burst_left--;
	endtask

	task automatic settle_idle();
		code_if.valid <= 1'b0;
		while (pix_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(input logic [srle_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] data);
		settle_idle();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		@(posedge clk);
		while (cfg_if.ready !== 1'b1) @(posedge clk);
		cfg_if.valid <= 1'b0;
		case (idx)
			srle_pkg::REG_FRAME_WIDTH: fw_q = data;
			srle_pkg::REG_X_OFFSET: x_off_q = data[7:0];
			srle_pkg::REG_Y_OFFSET: y_off_q = data[7:0];
			default: ;
		endcase
	endtask

	task automatic send_random_line();
		int unsigned n_cmds;
		int unsigned k;
		int unsigned pick;
		int unsigned n_ops;
		int unsigned cut;
		logic [7:0] cmd;
		n_cmds = $urandom_range(1, 8);
		for (k = 0; k < n_cmds; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				cmd = 8'($urandom_range(srle_pkg::SKIP_MIN, 8'hFF));
				n_ops = 0;
			end else if (pick < 55) begin
				if ($urandom_range(0, 7) == 0)
					cmd = 8'($urandom_range(srle_pkg::RUN_MIN, srle_pkg::RUN_MAX));
				else
					cmd = 8'($urandom_range(srle_pkg::RUN_MIN, 8'h4A));
				n_ops = 1;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					cmd = srle_pkg::LIT_NONE;
				else if (pick == 1)
					cmd = RUN_BASE;
				else
					cmd = 8'($urandom_range(1, 6));
				n_ops = 32'(cmd);
			end
			send_byte(cmd, k == 0);
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_ops) : n_ops;
			repeat (cut) send_byte(8'($urandom_range(0, 255)), 1'b0);
			if (cut < n_ops)
				break;
		end
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned target;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			steady = ($urandom_range(0, 4) == 0);
			send_random_line();
		end
		steady = 1'b0;
	endtask

	function automatic void add_row(input script_row_t r);
		script.insert(script.size(), r);
	endfunction

	function automatic script_row_t byte_row(input logic [7:0] b, input logic ls);
		script_row_t r;
		r = '0;
		r.kind = ROW_BYTE;
		r.data = {8'd0, b};
		r.ls = ls;
		return r;
	endfunction

	function automatic script_row_t reg_row(input logic [srle_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] data);
		script_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic script_row_t known_row(input logic [7:0] b, input logic ls,
		input logic [15:0] column, input logic [15:0] row, input logic oor);
		script_row_t r;
		r = byte_row(b, ls);
		r.typed = 1'b1;
		r.want = '{column: column, row: row, value: b, oor: oor, last: 1'b1};
		return r;
	endfunction

	initial begin
		code_if.valid <= 1'b0;
		code_if.code_byte <= 8'd0;
		code_if.line_start <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= srle_pkg::REG_FRAME_WIDTH;
		cfg_if.data <= 16'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		add_row(byte_row(8'h01, 1'b0));
		add_row(known_row(8'hAB, 1'b0, 16'd0, 16'd0, 1'b0));
		add_row(byte_row(8'h41, 1'b0));
		add_row(known_row(8'hFF, 1'b0, 16'd1, 16'd0, 1'b0));
		add_row(reg_row(srle_pkg::REG_Y_OFFSET, 16'h0037));
		add_row(reg_row(srle_pkg::REG_X_OFFSET, 16'h0012));
		add_row(byte_row(8'h00, 1'b1));
		add_row(byte_row(8'h7F, 1'b0));
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'hFF, 1'b0));
		add_row(byte_row(8'h03, 1'b0));
		add_row(byte_row(8'h55, 1'b0));
		add_row(byte_row(8'hAA, 1'b0));
		add_row(reg_row(srle_pkg::REG_FRAME_WIDTH, 16'd210));
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'h80, 1'b0));
		add_row(byte_row(8'h43, 1'b0));
		add_row(byte_row(8'h05, 1'b1));
		add_row(known_row(8'h12, 1'b0, 16'h0012, 16'h0038, 1'b0));
		add_row(byte_row(8'hC0, 1'b1));
		add_row(reg_row(srle_pkg::REG_Y_OFFSET, 16'h0000));
		add_row(byte_row(8'h42, 1'b1));
		add_row(byte_row(8'h7E, 1'b0));
		add_row(reg_row(srle_pkg::REG_FRAME_WIDTH, 16'd0));
		add_row(byte_row(8'h01, 1'b0));
		add_row(known_row(8'h00, 1'b0, 16'h0014, 16'h003A, 1'b1));

		foreach (script[i]) begin
			if (script[i].kind == ROW_REG) begin
				program_reg(script[i].idx, script[i].data);
			end else begin
				send_byte(script[i].data[7:0], script[i].ls);
				if (script[i].typed)
					pix_expected[pix_expected.size() - 1] = script[i].want;
			end
		end

		program_reg(srle_pkg::REG_FRAME_WIDTH, 16'($urandom_range(64, 400)));
		program_reg(srle_pkg::REG_X_OFFSET, 16'($urandom_range(0, 255)));
		program_reg(srle_pkg::REG_Y_OFFSET, 16'($urandom_range(0, 255)));
		run_random(140);

		// A zero frame width flags every write, however far the skips push the column.
		program_reg(srle_pkg::REG_FRAME_WIDTH, 16'd0);
		program_reg(srle_pkg::REG_X_OFFSET, 16'd255);
		program_reg(srle_pkg::REG_Y_OFFSET, 16'd255);
		run_random(100);
		send_byte(8'hFF, 1'b1);
		repeat (3) send_byte(8'hFF, 1'b0);
		send_byte(8'h45, 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_byte(8'h02, 1'b0);
		repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b0);

		program_reg(srle_pkg::REG_FRAME_WIDTH, 16'hFFFF);
		program_reg(srle_pkg::REG_X_OFFSET, 16'd0);
		run_random(70);

		program_reg(srle_pkg::REG_FRAME_WIDTH, 16'd1);
		program_reg(srle_pkg::REG_X_OFFSET, 16'($urandom_range(0, 255)));
		run_random(110);

		settle_idle();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sprite_line_rle_decoder_core.f */
+incdir+rtl
rtl/srle_pkg.sv
rtl/srle_if.sv
rtl/srle_dp.sv
rtl/srle_ctrl.sv
rtl/sprite_line_rle_decoder_core.sv
tb/sv/sprite_line_rle_decoder_core_tb.sv
